FILE: hdl/hmn_pkg.sv
// shared types and constants of the height map normal generator
package hmn_pkg;

  localparam int HEIGHT_BITS = 16;
  localparam int DIFF_W      = HEIGHT_BITS + 1;
  localparam int MSQ_W       = 2 * HEIGHT_BITS;
  localparam int S_W         = 2 * HEIGHT_BITS + 2;
  localparam int QUO_W       = 31;
  localparam int SQ_W        = 32;
  localparam int Q_W         = 15;
  localparam int NRM_W       = Q_W + 1;
  localparam int ROW_W       = 16;
  localparam int GW_W        = 11;
  localparam int CFG_W       = 16;
  localparam int STEP_W      = 5;

  localparam logic [STEP_W-1:0] DIV_STEPS = 5'd30;
  localparam logic [STEP_W-1:0] SQ_STEPS  = 5'd16;
  localparam logic [SQ_W-1:0]   SQ_ONE_INIT = 32'h4000_0000;

  // 2.0 in Q8.8 is 512, squared
  localparam logic [MSQ_W-1:0] Y_SQ = 32'h0004_0000;

  localparam logic [GW_W-1:0]  GRID_WIDTH_RESET = 11'd256;
  localparam logic [ROW_W-1:0] GRID_DEPTH_RESET = 16'd256;

  localparam logic [0:0] REG_GRID_WIDTH = 1'b0;
  localparam logic [0:0] REG_GRID_DEPTH = 1'b1;

  localparam logic [1:0] RD_LEFT  = 2'd0;
  localparam logic [1:0] RD_SELF  = 2'd1;
  localparam logic [1:0] RD_RIGHT = 2'd2;

  localparam logic [1:0] JOB_UPPER_MID = 2'd0;
  localparam logic [1:0] JOB_LOWER_MID = 2'd1;
  localparam logic [1:0] JOB_UPPER_END = 2'd2;
  localparam logic [1:0] JOB_LOWER_END = 2'd3;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       rd_en;
    logic [1:0] rd_phase;
    logic       load_job;
    logic [1:0] job;
    logic       sq_x;
    logic       sq_z;
    logic       sum;
    logic       norm_start;
    logic [1:0] comp;
    logic       norm_capture;
    logic       wr_prev;
    logic       wr_last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] job_en;
    logic       norm_done;
  } stat_t;

endpackage

FILE: hdl/heightmap_normal_generator.sv
// Central-difference normal generator for a raster height map. Heights (signed Q8.8) enter
// one word at a time; each word yields up to four unit normals (Q1.14) tagged with column
// and row, running one row plus one sample behind the input, with the last row flushed as
// it arrives. Each word yields its normals (at most four) before the next is taken, and an
// output stall holds the flow; each normal passes through the bit-serial divider and
// square root in the normalizer, which the three components share in turn. Two row stores
// of MAX_WIDTH entries swap roles at each row end and need no clearing after reset.
module heightmap_normal_generator #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [0:0]                             cfg_index,
  input  logic [hmn_pkg::CFG_W-1:0]              cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [hmn_pkg::HEIGHT_BITS-1:0] height,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [hmn_pkg::NRM_W-1:0]       normal_x,
  output logic [hmn_pkg::Q_W-1:0]                normal_y,
  output logic signed [hmn_pkg::NRM_W-1:0]       normal_z,
  output logic [$clog2(MAX_WIDTH)-1:0]           column,
  output logic [hmn_pkg::ROW_W-1:0]              row,
  output logic                                   frame_end
);
  import hmn_pkg::*;

  cmd_t  cmd;
  stat_t status;

  hmn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hmn_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .height    (height),
    .cmd       (cmd),
    .status    (status),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .column    (column),
    .row       (row),
    .frame_end (frame_end)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a normal is pending");

  a_y_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_y != '0)
    else $error("normal y component is zero");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_x <= 16'sd16384) && (normal_x >= -16'sd16384) &&
                  (normal_z <= 16'sd16384) && (normal_z >= -16'sd16384))
    else $error("normal component beyond unit length");
`endif

endmodule

FILE: hdl/hmn_norm.sv
// bit-serial normalizer: round(sqrt(msq) * 16384 / sqrt(s)) via divide then square root
module hmn_norm (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [hmn_pkg::MSQ_W-1:0] msq,
  input  logic [hmn_pkg::S_W-1:0] s,
  output logic                    done,
  output logic [hmn_pkg::Q_W-1:0] q
);
  import hmn_pkg::*;

  localparam int RW = S_W + 1;

  typedef enum logic [4:0] {
    N_IDLE = 5'b00001,
    N_DIV  = 5'b00010,
    N_SQI  = 5'b00100,
    N_SQ   = 5'b01000,
    N_FIN  = 5'b10000
  } nstate_t;

  nstate_t          state;
  logic [STEP_W-1:0] cnt;
  logic [RW-1:0]    rem;
  logic [QUO_W-1:0] quo;
  logic [SQ_W-1:0]  op;
  logic [SQ_W-1:0]  res;
  logic [SQ_W-1:0]  one;

  logic [RW-1:0]    s_ext;
  logic [RW-1:0]    msq_ext;
  logic             ge0;
  logic [RW-1:0]    r2;
  logic             ge;
  logic [SQ_W-1:0]  t;
  logic             ge_s;
  logic [SQ_W:0]    rp1;

  always_comb begin
    s_ext   = RW'(s);
    msq_ext = RW'(msq);
    ge0     = msq_ext >= s_ext;
    r2      = {rem[RW-2:0], 1'b0};
    ge      = r2 >= s_ext;
    t       = res + one;
    ge_s    = op >= t;
    rp1     = {1'b0, res} + (SQ_W+1)'(1);
    q       = rp1[Q_W:1];
    done    = state == N_FIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            state <= N_DIV;
            cnt   <= DIV_STEPS;
          end
        end
        N_DIV: begin
          cnt <= cnt - STEP_W'(1);
          if (cnt == STEP_W'(1)) state <= N_SQI;
        end
        N_SQI: begin
          state <= N_SQ;
          cnt   <= SQ_STEPS;
        end
        N_SQ: begin
          cnt <= cnt - STEP_W'(1);
          if (cnt == STEP_W'(1)) state <= N_FIN;
        end
        N_FIN: state <= N_IDLE;
        default: state <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == N_IDLE && start) begin
      rem <= ge0 ? msq_ext - s_ext : msq_ext;
      quo <= QUO_W'(ge0);
    end else if (state == N_DIV) begin
      rem <= ge ? r2 - s_ext : r2;
      quo <= {quo[QUO_W-2:0], ge};
    end
    if (state == N_SQI) begin
      op  <= SQ_W'(quo);
      res <= '0;
      one <= SQ_ONE_INIT;
    end else if (state == N_SQ) begin
      if (ge_s) begin
        op  <= op - t;
        res <= (res >> 1) + one;
      end else begin
        res <= res >> 1;
      end
      one <= one >> 2;
    end
  end

endmodule

FILE: hdl/hmn_dp.sv
// datapath: config registers, row stores, counters, operand selection, normalizer, result registers
module hmn_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [hmn_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [hmn_pkg::HEIGHT_BITS-1:0] height,
  input  hmn_pkg::cmd_t                     cmd,
  output hmn_pkg::stat_t                    status,
  output logic signed [hmn_pkg::NRM_W-1:0]  normal_x,
  output logic [hmn_pkg::Q_W-1:0]           normal_y,
  output logic signed [hmn_pkg::NRM_W-1:0]  normal_z,
  output logic [$clog2(MAX_WIDTH)-1:0]      column,
  output logic [hmn_pkg::ROW_W-1:0]         row,
  output logic                              frame_end
);
  import hmn_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = 16;
  localparam int HB    = HEIGHT_BITS;

  logic [GW_W-1:0]  grid_width_reg;
  logic [ROW_W-1:0] grid_depth_reg;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic             sel;
  logic signed [HB-1:0] p0, p1, h_reg;
  logic signed [HB-1:0] n_m2, n_m1, n_0, o_m1, o_0;
  logic             norm_done;

  logic [CNT_W-1:0] gw_ext, w_eff;
  logic [COL_W-1:0] w_last, c, c_m1, c_m2;
  logic [ROW_W-1:0] d_last;
  logic             last_col, last_row, c_pos, r_pos, r_gt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width_reg <= GRID_WIDTH_RESET;
      grid_depth_reg <= GRID_DEPTH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_width_reg <= cfg_data[GW_W-1:0];
      end else begin
        grid_depth_reg <= cfg_data;
      end
    end
  end

  always_comb begin
    gw_ext = CNT_W'(grid_width_reg);
    if (grid_width_reg == '0) w_eff = CNT_W'(1);
    else if (gw_ext > CNT_W'(MAX_WIDTH)) w_eff = CNT_W'(MAX_WIDTH);
    else w_eff = gw_ext;
    w_last   = COL_W'(w_eff - CNT_W'(1));
    d_last   = (grid_depth_reg == '0) ? '0 : grid_depth_reg - ROW_W'(1);
    last_col = col_cnt >= w_last;
    last_row = row_cnt >= d_last;
    c        = last_col ? w_last : col_cnt;
    c_m1     = c - COL_W'(1);
    c_m2     = c - COL_W'(2);
    c_pos    = c != '0;
    r_pos    = row_cnt != '0;
    r_gt1    = row_cnt > ROW_W'(1);
    status.job_en = {last_col && last_row, last_col && r_pos,
                     c_pos && last_row, c_pos && r_pos};
    status.norm_done = norm_done;
  end

  // row stores: sel picks which physical bank holds the newer row
  logic [HB-1:0]    mem0 [MAX_WIDTH];
  logic [HB-1:0]    mem1 [MAX_WIDTH];
  logic [HB-1:0]    q0, q1, wd;
  logic [COL_W-1:0] newer_ra, older_ra, ra0, ra1, wa;
  logic             wr_go, we0, we1;
  logic [HB-1:0]    newer_q, older_q;

  always_comb begin
    unique case (cmd.rd_phase)
      RD_LEFT: begin
        newer_ra = c_m2;
        older_ra = c_m1;
      end
      RD_SELF: begin
        newer_ra = c_m1;
        older_ra = c;
      end
      default: begin
        newer_ra = c;
        older_ra = c;
      end
    endcase
    ra0     = sel ? older_ra : newer_ra;
    ra1     = sel ? newer_ra : older_ra;
    wa      = cmd.wr_last ? c : c_m1;
    wd      = cmd.wr_last ? h_reg : p0;
    wr_go   = (cmd.wr_prev && c_pos) || (cmd.wr_last && last_col);
    we0     = wr_go && sel;
    we1     = wr_go && !sel;
    newer_q = sel ? q1 : q0;
    older_q = sel ? q0 : q1;
  end

  always_ff @(posedge clk) begin
    if (we0) mem0[wa] <= wd;
    q0 <= mem0[ra0];
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[wa] <= wd;
    q1 <= mem1[ra1];
  end

  logic       rd_cap;
  logic [1:0] rd_ph_q;

  always_ff @(posedge clk) begin
    if (rst) rd_cap <= 1'b0;
    else rd_cap <= cmd.rd_en;
    rd_ph_q <= cmd.rd_phase;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) h_reg <= height;
    if (rd_cap) begin
      unique case (rd_ph_q)
        RD_LEFT: begin
          n_m2 <= newer_q;
          o_m1 <= older_q;
        end
        RD_SELF: begin
          n_m1 <= newer_q;
          o_0  <= older_q;
        end
        default: n_0 <= newer_q;
      endcase
    end
  end

  // counters and previous samples advance after the row store writes
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      sel     <= 1'b0;
      p0      <= '0;
      p1      <= '0;
    end else if (cmd.wr_last) begin
      p1 <= p0;
      p0 <= h_reg;
      if (last_col) begin
        sel     <= ~sel;
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // neighbor selection, clamped at the borders
  logic signed [HB-1:0]     left, right, up, down;
  logic signed [DIFF_W-1:0] ax, az, ax_abs, az_abs;
  logic [COL_W-1:0]         job_col;
  logic [ROW_W-1:0]         job_row;

  always_comb begin
    unique case (cmd.job)
      JOB_UPPER_MID: begin
        left  = (c_m1 != '0) ? n_m2 : n_m1;
        right = n_0;
        up    = r_gt1 ? o_m1 : n_m1;
        down  = p0;
      end
      JOB_LOWER_MID: begin
        left  = (c_m1 != '0) ? p1 : p0;
        right = h_reg;
        up    = r_pos ? n_m1 : p0;
        down  = p0;
      end
      JOB_UPPER_END: begin
        left  = c_pos ? n_m1 : n_0;
        right = n_0;
        up    = r_gt1 ? o_0 : n_0;
        down  = h_reg;
      end
      default: begin
        left  = c_pos ? p0 : h_reg;
        right = h_reg;
        up    = r_pos ? n_0 : h_reg;
        down  = h_reg;
      end
    endcase
    ax      = {left[HB-1], left} - {right[HB-1], right};
    az      = {up[HB-1], up} - {down[HB-1], down};
    ax_abs  = ax[DIFF_W-1] ? -ax : ax;
    az_abs  = az[DIFF_W-1] ? -az : az;
    job_col = (cmd.job == JOB_UPPER_MID || cmd.job == JOB_LOWER_MID) ? c_m1 : c;
    job_row = (cmd.job == JOB_UPPER_MID || cmd.job == JOB_UPPER_END) ?
              row_cnt - ROW_W'(1) : row_cnt;
  end

  logic [HB-1:0]    mx, mz, mult_a;
  logic             sx, sz;
  logic [MSQ_W-1:0] prod, sqx, sqz, msq;
  logic [S_W-1:0]   s_reg;
  logic [Q_W-1:0]   nq;
  logic signed [NRM_W-1:0] nq_pos, nq_neg;

  always_comb begin
    mult_a = cmd.sq_z ? mz : mx;
    prod   = MSQ_W'(mult_a) * MSQ_W'(mult_a);
    unique case (cmd.comp)
      COMP_X:  msq = sqx;
      COMP_Y:  msq = Y_SQ;
      default: msq = sqz;
    endcase
    nq_pos = signed'({1'b0, nq});
    nq_neg = -nq_pos;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_job) begin
      mx        <= ax_abs[HB-1:0];
      mz        <= az_abs[HB-1:0];
      sx        <= ax[DIFF_W-1];
      sz        <= az[DIFF_W-1];
      column    <= job_col;
      row       <= job_row;
      frame_end <= cmd.job == JOB_LOWER_END;
    end
    if (cmd.sq_x) sqx <= prod;
    if (cmd.sq_z) sqz <= prod;
    if (cmd.sum) s_reg <= S_W'(sqx) + S_W'(sqz) + S_W'(Y_SQ);
    if (cmd.norm_capture) begin
      unique case (cmd.comp)
        COMP_X:  normal_x <= sx ? nq_neg : nq_pos;
        COMP_Y:  normal_y <= nq;
        default: normal_z <= sz ? nq_neg : nq_pos;
      endcase
    end
  end

  hmn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.norm_start),
    .msq   (msq),
    .s     (s_reg),
    .done  (norm_done),
    .q     (nq)
  );

endmodule

FILE: hdl/hmn_ctrl.sv
// controller: sequences reads, up to four normals, row store writes per input word
module hmn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  hmn_pkg::stat_t status,
  output hmn_pkg::cmd_t  cmd
);
  import hmn_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_RD0    = 14'h0002,
    S_RD1    = 14'h0004,
    S_RD2    = 14'h0008,
    S_RDW    = 14'h0010,
    S_JOB    = 14'h0020,
    S_SQX    = 14'h0040,
    S_SQZ    = 14'h0080,
    S_SUM    = 14'h0100,
    S_NSTART = 14'h0200,
    S_NWAIT  = 14'h0400,
    S_EMIT   = 14'h0800,
    S_WR0    = 14'h1000,
    S_WR1    = 14'h2000
  } state_t;

  state_t     state;
  logic [1:0] job;
  logic [1:0] comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= JOB_UPPER_MID;
      comp  <= COMP_X;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RD0;
            job   <= JOB_UPPER_MID;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: state <= S_RD2;
        S_RD2: state <= S_RDW;
        S_RDW: state <= S_JOB;
        S_JOB: begin
          if (status.job_en[job]) begin
            state <= S_SQX;
            comp  <= COMP_X;
          end else if (job == JOB_LOWER_END) begin
            state <= S_WR0;
          end else begin
            job <= job + 2'd1;
          end
        end
        S_SQX: state <= S_SQZ;
        S_SQZ: state <= S_SUM;
        S_SUM: state <= S_NSTART;
        S_NSTART: state <= S_NWAIT;
        S_NWAIT: begin
          if (status.norm_done) begin
            if (comp == COMP_Z) begin
              state <= S_EMIT;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_NSTART;
            end
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (job == JOB_LOWER_END) begin
              state <= S_WR0;
            end else begin
              job   <= job + 2'd1;
              state <= S_JOB;
            end
          end
        end
        S_WR0: state <= S_WR1;
        S_WR1: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready         = state == S_IDLE;
    out_valid        = state == S_EMIT;
    cmd.latch_in     = (state == S_IDLE) && in_valid;
    cmd.rd_en        = (state == S_RD0) || (state == S_RD1) || (state == S_RD2);
    cmd.rd_phase     = (state == S_RD0) ? RD_LEFT : ((state == S_RD1) ? RD_SELF : RD_RIGHT);
    cmd.load_job     = (state == S_JOB) && status.job_en[job];
    cmd.job          = job;
    cmd.sq_x         = state == S_SQX;
    cmd.sq_z         = state == S_SQZ;
    cmd.sum          = state == S_SUM;
    cmd.norm_start   = state == S_NSTART;
    cmd.comp         = comp;
    cmd.norm_capture = (state == S_NWAIT) && status.norm_done;
    cmd.wr_prev      = state == S_WR0;
    cmd.wr_last      = state == S_WR1;
  end

endmodule

FILE: bench/tb_top.sv
// testbench of the height map normal generator: predicted normals checked against the block
`timescale 1ns / 100ps

module tb_top;
  import hmn_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int CYCLE_CAP  = 6000000;
  localparam int SETTLE     = 200;

  typedef struct packed {
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
    logic [9:0]         col;
    logic [15:0]        rw;
    logic               fe;
  } normal_t;

  class normal_scoreboard;
    logic signed [15:0] row_bank[2][MAX_W];
    bit                 newer_sel;
    int unsigned        col_cnt, row_cnt, width_reg, depth_reg;
    logic signed [15:0] prev0, prev1;
    normal_t            expected_normals[$];
    int                 errors;

    function new();
      for (int i = 0; i < MAX_W; i++) begin
        row_bank[0][i] = '0;
        row_bank[1][i] = '0;
      end
      newer_sel = 0;
      col_cnt = 0;
      row_cnt = 0;
      prev0 = '0;
      prev1 = '0;
      width_reg = GRID_WIDTH_RESET;
      depth_reg = GRID_DEPTH_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_GRID_WIDTH) width_reg = val[GW_W-1:0];
      else depth_reg = val;
    endfunction

    // round(m * 16384 / sqrt(s)) by bitwise search, nearest with ties up
    function longint unsigned unit_mag(longint unsigned m, longint unsigned s);
      longint unsigned t, q, b, cand, d;
      t = (m * m) << 30;
      q = 0;
      for (b = 16384; b != 0; b >>= 1) begin
        cand = q | b;
        if (cand <= 16384) begin
          d = 2 * cand - 1;
          if (d * d * s <= t) q = cand;
        end
      end
      return q;
    endfunction

    function void push_normal(longint left, longint right, longint up, longint down,
                              int unsigned c, int unsigned r, bit fe);
      longint ax, az;
      longint unsigned mx, mz, s, qx, qy, qz;
      normal_t n;
      ax = left - right;
      az = up - down;
      mx = ax < 0 ? -ax : ax;
      mz = az < 0 ? -az : az;
      s = mx * mx + 512 * 512 + mz * mz;
      qx = unit_mag(mx, s);
      qy = unit_mag(512, s);
      qz = unit_mag(mz, s);
      n.nx = ax < 0 ? -qx : qx;
      n.ny = qy;
      n.nz = az < 0 ? -qz : qz;
      n.col = c;
      n.rw = r;
      n.fe = fe;
      expected_normals.push_back(n);
    endfunction

    function void note_height(logic signed [15:0] h);
      int unsigned w, d, c, r, k;
      bit last_col, last_row;
      longint self_h, up;
      w = width_reg == 0 ? 1 : (width_reg > MAX_W ? MAX_W : width_reg);
      d = depth_reg == 0 ? 1 : depth_reg;
      c = col_cnt > w - 1 ? w - 1 : col_cnt;
      r = row_cnt;
      last_col = col_cnt >= w - 1;
      last_row = r >= d - 1;
      if (c >= 1) begin
        k = c - 1;
        if (r >= 1) begin
          self_h = row_bank[newer_sel][k];
          up = r > 1 ? row_bank[!newer_sel][k] : self_h;
          push_normal(k > 0 ? row_bank[newer_sel][k-1] : self_h,
                      row_bank[newer_sel][k+1], up, prev0, k, r - 1, 0);
        end
        if (last_row) begin
          up = r > 0 ? row_bank[newer_sel][k] : prev0;
          push_normal(k > 0 ? prev1 : prev0, h, up, prev0, k, r, 0);
        end
      end
      if (last_col) begin
        k = c;
        if (r >= 1) begin
          self_h = row_bank[newer_sel][k];
          up = r > 1 ? row_bank[!newer_sel][k] : self_h;
          push_normal(k > 0 ? row_bank[newer_sel][k-1] : self_h, self_h, up, h, k, r - 1, 0);
        end
        if (last_row) begin
          up = r > 0 ? row_bank[newer_sel][k] : h;
          push_normal(k > 0 ? prev0 : h, h, up, h, k, r, 1);
        end
      end
      if (c >= 1) row_bank[!newer_sel][c-1] = prev0;
      if (last_col) row_bank[!newer_sel][c] = h;
      prev1 = prev0;
      prev0 = h;
      if (last_col) begin
        newer_sel = !newer_sel;
        col_cnt = 0;
        row_cnt = last_row ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
        col_cnt++;
      end
    endfunction

    function void check_normal(normal_t got);
      normal_t want;
      if (expected_normals.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected normal: %p", got);
        return;
      end
      want = expected_normals.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"normal (%0d,%0d): want x=%0d y=%0d z=%0d fe=%0b",
                    " got x=%0d y=%0d z=%0d c=%0d r=%0d fe=%0b"},
                   want.rw, want.col, want.nx, want.ny, want.nz, want.fe,
                   got.nx, got.ny, got.nz, got.col, got.rw, got.fe);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [HEIGHT_BITS-1:0] height;
  logic signed [NRM_W-1:0] normal_x, normal_z;
  logic [Q_W-1:0] normal_y;
  logic [9:0] column;
  logic [ROW_W-1:0] row;
  logic frame_end;

  normal_scoreboard sb = new();
  int snd_idle, rcv_idle;
  bit hold_req;
  int sent;
  logic signed [15:0] last_h;

  heightmap_normal_generator #(.MAX_WIDTH(MAX_W)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .height(height),
    .out_valid(out_valid), .out_ready(out_ready),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .column(column), .row(row), .frame_end(frame_end)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_normal('{normal_x, normal_y, normal_z, column, row, frame_end});
      if (hold_req) begin
        hold_req = 0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= $urandom_range(99) >= rcv_idle;
      end
    end
  end

  task automatic push_height(logic signed [15:0] h);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    height <= h;
    do @(posedge clk); while (!in_ready);
    sb.note_height(h);
    last_h = h;
    sent++;
  endtask

  // pause the sender until every expected normal is back
  task automatic drain();
    in_valid <= 0;
    while (sb.expected_normals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] d);
    cfg_we <= 1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_GRID_DEPTH;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(REG_GRID_WIDTH, w);
    sb.set_reg(REG_GRID_DEPTH, d);
  endtask

  function automatic logic signed [15:0] next_height();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return last_h + $signed(16'($urandom_range(512))) - 16'sd256;
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return last_h + $signed(16'($urandom_range(8192))) - 16'sd4096;
    endcase
  endfunction

  task automatic random_frames(int target);
    int w, d, stop_at;
    stop_at = sent + target;
    while (sent < stop_at) begin
      w = $urandom_range(9) == 0 ? $urandom_range(16, 40) : $urandom_range(1, 8);
      d = $urandom_range(1, 5);
      drain();
      set_grid(w, d);
      repeat (w * d) push_height(next_height());
    end
  endtask

  initial begin
    logic signed [15:0] grid3[9];
    grid3 = '{16'sh7FFF, 16'sh8000, 16'sh0000,
              16'sh8000, 16'sh7FFF, 16'sh0001,
              16'sh0000, 16'shFFFF, 16'sh7FFF};
    rst <= 1;
    cfg_we <= 0;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= '0;
    in_valid <= 0;
    height <= '0;
    hold_req = 0;
    sent = 0;
    last_h = 0;
    snd_idle = 29;
    rcv_idle = 68;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes on a 3x3 grid, then a lone point, then a single two-sample row, then a one-column frame of four
    set_grid(3, 3);
    foreach (grid3[i]) push_height(grid3[i]);
    drain();
    set_grid(0, 0);
    push_height(16'sh1234);
    drain();
    set_grid(2, 1);
    push_height(16'sh8000);
    push_height(16'sh7FFF);
    drain();
    set_grid(1, 4);
    repeat (4) push_height(next_height());

    random_frames(100);

    // deepest frame setting, then shrink depth at a row end to close the frame
    drain();
    set_grid(5, 65535);
    repeat (20) push_height(next_height());
    drain();
    set_grid(5, 0);
    repeat (5) push_height(next_height());

    snd_idle = 68;
    rcv_idle = 29;
    random_frames(100);

    snd_idle = 0;
    rcv_idle = 0;
    drain();
    set_grid(6, 4);
    hold_req = 1;
    repeat (24) push_height(next_height());
    random_frames(80);

    // widest rows, single-row frame, partly sent
    drain();
    set_grid(1024, 1);
    repeat (60) push_height(next_height());
    drain();

    if (sb.errors == 0 && sb.expected_normals.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
